>>> rtl/smd_pkg.sv
package smd_pkg;

  // Depth of each side's element buffer.
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned ELEM_W  = 64;
  localparam int unsigned COUNT_W = 32;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Input operation codes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Input word as seen on the port.
  typedef struct packed {
    logic              op;
    logic              side;
    logic [ELEM_W-1:0] element;
  } in_t;

  // Result word as seen on the port.
  typedef struct packed {
    logic [1:0]         kind;
    logic [ELEM_W-1:0]  merged_value;
    logic [COUNT_W-1:0] unique_count;
    logic               last_of_run;
  } out_t;

  // Classified command handed from the front to the engine.
  typedef enum logic [1:0] {
    CMD_PUSH_LEFT   = 2'd0,
    CMD_PUSH_RIGHT  = 2'd1,
    CMD_CLOSE_LEFT  = 2'd2,
    CMD_CLOSE_RIGHT = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ELEM_W-1:0] element;
  } cmd_t;

endpackage

>>> rtl/sorted_merge_dedup.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        in_data_i  (op, side, element)
// result    out        empty / pop        out_data_o (kind, merged_value, unique_count,
//                                                     last_of_run)
//
// For each word the engine takes the word, runs compare-and-pop steps while heads can
// leave (equal heads leave together in one step), sees that nothing more can leave, and
// then hands over the final result; a rejected word skips the compare-and-pop steps.
// Its single compare-and-pop engine does not take a new word until it is back in idle.
// Reset is asynchronous and active low and empties every buffer and queue.
// A full result queue stalls the engine; the input queue keeps taking words until full.
module sorted_merge_dedup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  smd_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output smd_pkg::out_t out_data_o
);

  logic          cmd_valid, cmd_ready;
  smd_pkg::cmd_t cmd;
  logic          res_valid, res_full;
  smd_pkg::out_t res;

  // Input queue and command decode.
  smd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Merge engine with both element buffers.
  smd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // Result queue toward the consumer.
  smd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_full_o  (res_full),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/smd_front.sv
module smd_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  smd_pkg::in_t in_data_i,
  output logic         cmd_valid_o,
  output smd_pkg::cmd_t cmd_o,
  input  logic         cmd_ready_i
);

  smd_pkg::cmd_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  smd_pkg::cmd_t cmd_in;
  logic          do_wr, do_rd;

  // Classify the incoming word by operation and side.
  always_comb begin
    cmd_in.element = in_data_i.element;
    case ({in_data_i.op, in_data_i.side})
      {smd_pkg::OP_PUSH, 1'b0}:  cmd_in.cmd = smd_pkg::CMD_PUSH_LEFT;
      {smd_pkg::OP_PUSH, 1'b1}:  cmd_in.cmd = smd_pkg::CMD_PUSH_RIGHT;
      {smd_pkg::OP_CLOSE, 1'b0}: cmd_in.cmd = smd_pkg::CMD_CLOSE_LEFT;
      default:                   cmd_in.cmd = smd_pkg::CMD_CLOSE_RIGHT;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign do_wr       = push && !full;
  assign do_rd       = cmd_valid_o && cmd_ready_i;

  // Two-entry command queue storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/smd_outq.sv
module smd_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  smd_pkg::out_t res_i,
  output logic          res_full_o,
  output logic          empty,
  input  logic          pop,
  output smd_pkg::out_t out_data_o
);

  smd_pkg::out_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          do_wr, do_rd;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign out_data_o = slot_q[rd_q];
  assign do_wr      = res_valid_i && !res_full_o;
  assign do_rd      = pop && !empty;

  // Two-entry result queue storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= res_i;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/smd_back.sv
module smd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  smd_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output smd_pkg::out_t res_o,
  input  logic          res_full_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  localparam logic [smd_pkg::IDX_W-1:0]  LastIdx  = smd_pkg::IDX_W'(smd_pkg::FIFO_DEPTH - 1);
  localparam logic [smd_pkg::FILL_W-1:0] DepthFill = smd_pkg::FILL_W'(smd_pkg::FIFO_DEPTH);
  localparam logic [smd_pkg::FILL_W:0]   DepthSum  = (smd_pkg::FILL_W + 1)'(smd_pkg::FIFO_DEPTH);

  state_e state_q, state_d;

  logic [smd_pkg::ELEM_W-1:0] left_mem_q  [smd_pkg::FIFO_DEPTH];
  logic [smd_pkg::ELEM_W-1:0] right_mem_q [smd_pkg::FIFO_DEPTH];

  logic [smd_pkg::FILL_W-1:0]  lfill_q, lfill_d, rfill_q, rfill_d;
  logic [smd_pkg::IDX_W-1:0]   lhead_q, lhead_d, rhead_q, rhead_d;
  logic                        lclosed_q, lclosed_d, rclosed_q, rclosed_d;
  logic                        seen_q, seen_d;
  logic [smd_pkg::ELEM_W-1:0]  last_q, last_d;
  logic [smd_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        pend_valid_q, pend_valid_d;
  smd_pkg::out_t               pend_q, pend_d;

  logic                       room;
  logic [smd_pkg::ELEM_W-1:0] head_l, head_r, pop_val;
  logic                       pop_l, pop_r, send;
  logic                       new_res;
  smd_pkg::out_t              new_val;
  logic [smd_pkg::FILL_W:0]   lsum, rsum;
  logic [smd_pkg::IDX_W-1:0]  ltail, rtail;
  logic                       wr_l, wr_r;

  assign room        = !res_full_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && room;

  // Head reads of both element buffers.
  assign head_l = left_mem_q[lhead_q];
  assign head_r = right_mem_q[rhead_q];

  // Tail positions, wrapped at the buffer depth.
  always_comb begin
    lsum  = (smd_pkg::FILL_W + 1)'(lhead_q) + (smd_pkg::FILL_W + 1)'(lfill_q);
    rsum  = (smd_pkg::FILL_W + 1)'(rhead_q) + (smd_pkg::FILL_W + 1)'(rfill_q);
    if (lsum >= DepthSum) lsum = lsum - DepthSum;
    if (rsum >= DepthSum) rsum = rsum - DepthSum;
    ltail = lsum[smd_pkg::IDX_W-1:0];
    rtail = rsum[smd_pkg::IDX_W-1:0];
  end

  // Pick which heads leave this cycle.
  always_comb begin
    pop_l = 1'b0;
    pop_r = 1'b0;
    if ((lfill_q != '0) && (rfill_q != '0)) begin
      pop_l = (head_l <= head_r);
      pop_r = (head_l >= head_r);
    end else if ((lfill_q != '0) && rclosed_q) begin
      pop_l = 1'b1;
    end else if ((rfill_q != '0) && lclosed_q) begin
      pop_r = 1'b1;
    end
    pop_val = pop_l ? head_l : head_r;
    send    = !seen_q || (pop_val != last_q);
  end

  // Sequencer: take a command, drain (not after a reject), flush, then take the next.
  always_comb begin
    state_d      = state_q;
    lfill_d      = lfill_q;
    rfill_d      = rfill_q;
    lhead_d      = lhead_q;
    rhead_d      = rhead_q;
    lclosed_d    = lclosed_q;
    rclosed_d    = rclosed_q;
    seen_d       = seen_q;
    last_d       = last_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    new_res      = 1'b0;
    new_val      = '0;
    wr_l         = 1'b0;
    wr_r         = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = pend_q;
    res_o.last_of_run = 1'b0;

    if (room) begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_d = ST_DRAIN;
            case (cmd_i.cmd)
              smd_pkg::CMD_PUSH_LEFT: begin
                if (lclosed_q || (lfill_q >= DepthFill)) begin
                  new_res = 1'b1;
                  new_val.kind = smd_pkg::KIND_REJECT;
                  state_d = ST_FLUSH;
                end else begin
                  wr_l    = 1'b1;
                  lfill_d = lfill_q + 1'b1;
                end
              end
              smd_pkg::CMD_PUSH_RIGHT: begin
                if (rclosed_q || (rfill_q >= DepthFill)) begin
                  new_res = 1'b1;
                  new_val.kind = smd_pkg::KIND_REJECT;
                  state_d = ST_FLUSH;
                end else begin
                  wr_r    = 1'b1;
                  rfill_d = rfill_q + 1'b1;
                end
              end
              smd_pkg::CMD_CLOSE_LEFT: begin
                if (lclosed_q) begin
                  new_res = 1'b1;
                  new_val.kind = smd_pkg::KIND_REJECT;
                  state_d = ST_FLUSH;
                end else begin
                  lclosed_d = 1'b1;
                end
              end
              default: begin
                if (rclosed_q) begin
                  new_res = 1'b1;
                  new_val.kind = smd_pkg::KIND_REJECT;
                  state_d = ST_FLUSH;
                end else begin
                  rclosed_d = 1'b1;
                end
              end
            endcase
          end
        end
        ST_DRAIN: begin
          if (pop_l || pop_r) begin
            if (pop_l) begin
              lfill_d = lfill_q - 1'b1;
              lhead_d = (lhead_q == LastIdx) ? '0 : lhead_q + 1'b1;
            end
            if (pop_r) begin
              rfill_d = rfill_q - 1'b1;
              rhead_d = (rhead_q == LastIdx) ? '0 : rhead_q + 1'b1;
            end
            if (send) begin
              new_res              = 1'b1;
              new_val.kind         = smd_pkg::KIND_VALUE;
              new_val.merged_value = pop_val;
              last_d               = pop_val;
              seen_d               = 1'b1;
              if (count_q != '1) count_d = count_q + 1'b1;
            end
          end else begin
            state_d = ST_FLUSH;
            if (lclosed_q && rclosed_q && (lfill_q == '0) && (rfill_q == '0)) begin
              // Both streams finished: report the count and start over.
              new_res              = 1'b1;
              new_val.kind         = smd_pkg::KIND_END;
              new_val.unique_count = count_q;
              lhead_d   = '0;
              rhead_d   = '0;
              lclosed_d = 1'b0;
              rclosed_d = 1'b0;
              seen_d    = 1'b0;
              last_d    = '0;
              count_d   = '0;
            end
          end
        end
        ST_FLUSH: begin
          state_d = ST_IDLE;
          if (pend_valid_q) begin
            res_valid_o       = 1'b1;
            res_o.last_of_run = 1'b1;
            pend_valid_d      = 1'b0;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase

      // A new result pushes out the one held back, which then cannot be the last.
      if (new_res) begin
        if (pend_valid_q) begin
          res_valid_o = 1'b1;
        end
        pend_d       = new_val;
        pend_valid_d = 1'b1;
      end
    end
  end

  // Element buffer writes.
  always_ff @(posedge clk_i) begin
    if (wr_l) left_mem_q[ltail] <= cmd_i.element;
    if (wr_r) right_mem_q[rtail] <= cmd_i.element;
  end

  // Held-back result payload.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lfill_q      <= '0;
      rfill_q      <= '0;
      lhead_q      <= '0;
      rhead_q      <= '0;
      lclosed_q    <= 1'b0;
      rclosed_q    <= 1'b0;
      seen_q       <= 1'b0;
      last_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      lfill_q      <= lfill_d;
      rfill_q      <= rfill_d;
      lhead_q      <= lhead_d;
      rhead_q      <= rhead_d;
      lclosed_q    <= lclosed_d;
      rclosed_q    <= rclosed_d;
      seen_q       <= seen_d;
      last_q       <= last_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule

>>> dv/smd_checker.sv
// Side codes shared by the stimulus and the checker.
package smd_sides_pkg;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_e;

endpackage

// Watches both channels of the merge block, predicts every result word from the
// accepted input words, and compares each popped word with the oldest prediction.
module smd_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  smd_pkg::in_t  word_i,
  input  logic          empty_i,
  input  logic          pop_i,
  input  smd_pkg::out_t result_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted state of the two element buffers and the union so far.
  logic [smd_pkg::ELEM_W-1:0]  side_buf [2][smd_pkg::FIFO_DEPTH];
  int unsigned                 side_fill [2];
  int unsigned                 side_rd [2];
  bit                          side_closed [2];
  bit                          seen_any;
  logic [smd_pkg::ELEM_W-1:0]  last_sent;
  logic [smd_pkg::COUNT_W-1:0] sent_count;

  // Result words still owed by the block, oldest first.
  smd_pkg::out_t union_results [$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  task automatic clear_union();
    for (int s = 0; s < 2; s++) begin
      side_fill[s]   = 0;
      side_rd[s]     = 0;
      side_closed[s] = 1'b0;
    end
    seen_any   = 1'b0;
    last_sent  = '0;
    sent_count = '0;
  endtask

  task automatic add_result(logic [1:0] kind, logic [smd_pkg::ELEM_W-1:0] value,
                            logic [smd_pkg::COUNT_W-1:0] count);
    smd_pkg::out_t r;
    r.kind         = kind;
    r.merged_value = value;
    r.unique_count = count;
    r.last_of_run  = 1'b0;
    union_results.insert(union_results.size(), r);
  endtask

  function automatic logic [smd_pkg::ELEM_W-1:0] take_head(int s);
    logic [smd_pkg::ELEM_W-1:0] v;
    v          = side_buf[s][side_rd[s]];
    side_rd[s] = (side_rd[s] + 1) % smd_pkg::FIFO_DEPTH;
    side_fill[s]--;
    return v;
  endfunction

  // A value equal to the one sent last is dropped; the count saturates.
  task automatic send_unique(logic [smd_pkg::ELEM_W-1:0] v);
    if (!seen_any || v != last_sent) begin
      add_result(smd_pkg::KIND_VALUE, v, '0);
      last_sent = v;
      seen_any  = 1'b1;
      if (sent_count != '1) begin
        sent_count++;
      end
    end
  endtask

  // Applies one accepted input word and queues the results it causes.
  task automatic predict_union(smd_pkg::in_t w);
    int                         first;
    int                         s;
    bit                         draining;
    logic [smd_pkg::ELEM_W-1:0] l_head;
    logic [smd_pkg::ELEM_W-1:0] r_head;
    first = union_results.size();
    s     = w.side;
    if (side_closed[s] ||
        (w.op == smd_pkg::OP_PUSH && side_fill[s] >= smd_pkg::FIFO_DEPTH)) begin
      add_result(smd_pkg::KIND_REJECT, '0, '0);
    end else begin
      if (w.op == smd_pkg::OP_PUSH) begin
        side_buf[s][(side_rd[s] + side_fill[s]) % smd_pkg::FIFO_DEPTH] = w.element;
        side_fill[s]++;
      end else begin
        side_closed[s] = 1'b1;
      end

      // Send the smaller head while both sides hold data; a closed and empty
      // side lets the other one pass straight through.
      draining = 1'b1;
      while (draining) begin
        if (side_fill[smd_sides_pkg::SIDE_LEFT] > 0 &&
            side_fill[smd_sides_pkg::SIDE_RIGHT] > 0) begin
          l_head = side_buf[smd_sides_pkg::SIDE_LEFT][side_rd[smd_sides_pkg::SIDE_LEFT]];
          r_head = side_buf[smd_sides_pkg::SIDE_RIGHT][side_rd[smd_sides_pkg::SIDE_RIGHT]];
          if (l_head < r_head) begin
            send_unique(take_head(smd_sides_pkg::SIDE_LEFT));
          end else if (l_head > r_head) begin
            send_unique(take_head(smd_sides_pkg::SIDE_RIGHT));
          end else begin
            void'(take_head(smd_sides_pkg::SIDE_RIGHT));
            send_unique(take_head(smd_sides_pkg::SIDE_LEFT));
          end
        end else if (side_fill[smd_sides_pkg::SIDE_LEFT] > 0 &&
                     side_closed[smd_sides_pkg::SIDE_RIGHT]) begin
          send_unique(take_head(smd_sides_pkg::SIDE_LEFT));
        end else if (side_fill[smd_sides_pkg::SIDE_RIGHT] > 0 &&
                     side_closed[smd_sides_pkg::SIDE_LEFT]) begin
          send_unique(take_head(smd_sides_pkg::SIDE_RIGHT));
        end else begin
          draining = 1'b0;
        end
      end

      // Both sides closed and drained: report the count and start over.
      if (side_closed[smd_sides_pkg::SIDE_LEFT] && side_closed[smd_sides_pkg::SIDE_RIGHT] &&
          side_fill[smd_sides_pkg::SIDE_LEFT] == 0 &&
          side_fill[smd_sides_pkg::SIDE_RIGHT] == 0) begin
        add_result(smd_pkg::KIND_END, '0, sent_count);
        clear_union();
      end
    end
    if (union_results.size() > first) begin
      union_results[union_results.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  // Inputs are sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i) begin : watch
    smd_pkg::out_t want;
    if (!rst_ni) begin
      clear_union();
      union_results.delete();
    end else begin
      if (push_i && !full_i) begin
        predict_union(word_i);
      end
      if (pop_i && !empty_i) begin
        if (union_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: kind %0d value 0x%0h",
                                    result_i.kind, result_i.merged_value));
        end else begin
          want = union_results.pop_front();
          if (result_i.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", result_i.kind, want.kind));
          end
          if (result_i.merged_value !== want.merged_value) begin
            report_mismatch($sformatf("merged_value 0x%0h, expected 0x%0h",
                                      result_i.merged_value, want.merged_value));
          end
          if (result_i.unique_count !== want.unique_count) begin
            report_mismatch($sformatf("unique_count %0d, expected %0d",
                                      result_i.unique_count, want.unique_count));
          end
          if (result_i.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      result_i.last_of_run, want.last_of_run));
          end
        end
      end
    end
    pending_o = union_results.size();
  end

endmodule

>>> dv/tb_sorted_merge_dedup.sv
module tb_sorted_merge_dedup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned WORD_TARGET    = 170;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum int {
    ACT_PUSH_LEFT,
    ACT_PUSH_RIGHT,
    ACT_CLOSE_LEFT,
    ACT_CLOSE_RIGHT
  } action_e;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          push;
  logic          full;
  smd_pkg::in_t  in_data;
  logic          empty;
  logic          pop;
  smd_pkg::out_t out_data;
  int unsigned   mismatches;
  int unsigned   pending;

  int unsigned words_sent;
  int unsigned burst_left;
  bit          steady;
  bit          hold_req;
  bit          second_hold_done;
  int unsigned stall_run;

  always #6 clk_i = ~clk_i;

  sorted_merge_dedup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  smd_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .word_i           (in_data),
    .empty_i          (empty),
    .pop_i            (pop),
    .result_i         (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Offers one word and waits until the block takes it. Words go out in bursts
  // of random length with random gaps, except in steady stretches.
  task automatic send_word(logic op, smd_sides_pkg::side_e side,
                           logic [smd_pkg::ELEM_W-1:0] element);
    smd_pkg::in_t w;
    int unsigned  gap;
    w.op      = op;
    w.side    = side;
    w.element = element;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    push    <= 1'b1;
    in_data <= w;
    do @(posedge clk_i); while (full);
    burst_left--;
    words_sent++;
  endtask

  // Short walk through the corner cases: equal heads, a dropped repeat that
  // leaves nothing, pass-through, all three rejections, and a full buffer.
  task automatic run_directed();
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_LEFT, '0);
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_RIGHT, '0);
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_LEFT, '0);
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_RIGHT, 64'd9);
    send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_LEFT, '1);
    send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_LEFT, '0);
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_LEFT, '1);
    send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_RIGHT, '1);
    send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_RIGHT, '0);
    // One word more than the left buffer holds, with repeats, while the right is empty.
    for (int i = 0; i <= smd_pkg::FIFO_DEPTH; i++) begin
      send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_LEFT,
                64'h8000_0000_0000_0000 + 64'(i / 2) * 64'd7);
    end
    send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_RIGHT, '0);
    send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_LEFT, '0);
  endtask

  // One merge: two ascending streams drawn from a shared sequence so that
  // values overlap, interleaved at random, each closed once it runs dry.
  // Now and then a random word is slipped in as noise.
  task automatic run_session();
    logic [smd_pkg::ELEM_W-1:0] left_vals [$];
    logic [smd_pkg::ELEM_W-1:0] right_vals [$];
    logic [smd_pkg::ELEM_W-1:0] v;
    action_e                    choices [$];
    action_e                    act;
    bit                         left_shut;
    bit                         right_shut;
    int unsigned                n_vals;
    n_vals = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 30) : $urandom_range(1, 10);
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = {$urandom, $urandom};
      2:       v = ~64'($urandom_range(0, 200));
      default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
    steady = ($urandom_range(0, 3) == 0);

    for (int i = 0; i < n_vals; i++) begin
      case ($urandom_range(0, 5))
        0:       v = v;
        1, 2:    v += $urandom_range(1, 3);
        3:       v += $urandom_range(4, 5000);
        4:       v += $urandom;
        default: v += {$urandom, $urandom} >> $urandom_range(8, 40);
      endcase
      case ($urandom_range(0, 4))
        0, 1: left_vals.insert(left_vals.size(), v);
        2, 3: right_vals.insert(right_vals.size(), v);
        default: begin
          left_vals.insert(left_vals.size(), v);
          right_vals.insert(right_vals.size(), v);
        end
      endcase
    end

    left_shut  = 1'b0;
    right_shut = 1'b0;
    while (!left_shut || !right_shut) begin
      choices.delete();
      if (left_vals.size() > 0) begin
        choices.insert(choices.size(), ACT_PUSH_LEFT);
      end else if (!left_shut) begin
        choices.insert(choices.size(), ACT_CLOSE_LEFT);
      end
      if (right_vals.size() > 0) begin
        choices.insert(choices.size(), ACT_PUSH_RIGHT);
      end else if (!right_shut) begin
        choices.insert(choices.size(), ACT_CLOSE_RIGHT);
      end
      act = choices[$urandom_range(0, choices.size() - 1)];
      if ($urandom_range(0, 11) == 0) begin
        send_word($urandom_range(0, 1) != 0, smd_sides_pkg::side_e'($urandom_range(0, 1)),
                  {$urandom, $urandom});
      end
      case (act)
        ACT_PUSH_LEFT: begin
          send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_LEFT, left_vals.pop_front());
        end
        ACT_PUSH_RIGHT: begin
          send_word(smd_pkg::OP_PUSH, smd_sides_pkg::SIDE_RIGHT, right_vals.pop_front());
        end
        ACT_CLOSE_LEFT: begin
          send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_LEFT, {$urandom, $urandom});
          left_shut = 1'b1;
        end
        default: begin
          send_word(smd_pkg::OP_CLOSE, smd_sides_pkg::SIDE_RIGHT, {$urandom, $urandom});
          right_shut = 1'b1;
        end
      endcase
    end
  endtask

  // Result side: phases of different pop rates, plus a long hold-off on request
  // so that the block backs up and refuses input.
  initial begin : result_sink
    int unsigned phase_len;
    int unsigned pop_pct;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       pop_pct = 100;
        1:       pop_pct = 75;
        2:       pop_pct = 35;
        default: pop_pct = 8;
      endcase
      repeat (phase_len) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          pop <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        pop <= ($urandom_range(1, 100) <= pop_pct);
      end
    end
  end

  // Ends the run when neither channel has moved a word for too long.
  initial begin : watchdog
    stall_run = 0;
    while (stall_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        stall_run = 0;
      end else begin
        stall_run++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    rst_ni           = 1'b0;
    push             = 1'b0;
    in_data          = '0;
    words_sent       = 0;
    burst_left       = 0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    second_hold_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    hold_req = 1'b1;
    while (words_sent < WORD_TARGET) begin
      if (!second_hold_done && words_sent >= 110) begin
        hold_req         = 1'b1;
        second_hold_done = 1'b1;
      end
      run_session();
    end
    push <= 1'b0;

    // Let the checker take in the last word, then wait for every owed word
    // and a while longer for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
